### src/transport_playhead_with_loop_top_defines.svh
// ---------------------------------------------------------------------------
// Transport playhead assertion macros
// Shared property macros for the transport playhead checker.
// ---------------------------------------------------------------------------
`ifndef TRANSPORT_PLAYHEAD_WITH_LOOP_TOP_DEFINES_SVH
`define TRANSPORT_PLAYHEAD_WITH_LOOP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/tph_pkg.sv
// ---------------------------------------------------------------------------
// Transport playhead package
// Widths, command and register codes, and shared types.
// ---------------------------------------------------------------------------
package tph_pkg;

    localparam int POSITION_BITS  = 48;
    localparam int RATE_FRAC_BITS = 12;
    localparam int RATE_BITS      = 16;
    localparam int COUNT_BITS     = 16;
    localparam int ACTION_BITS    = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int PROD_BITS      = COUNT_BITS + RATE_BITS;
    localparam int DELTA_BITS     = PROD_BITS - RATE_FRAC_BITS;
    localparam int CNT_BITS       = $clog2(POSITION_BITS);

    localparam logic [CNT_BITS-1:0]      MOD_LAST  = CNT_BITS'(POSITION_BITS - 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [RATE_BITS-1:0]     RATE_ONE  = RATE_BITS'(1 << RATE_FRAC_BITS);
    localparam logic [RATE_BITS:0]       RATE_MAX  = (RATE_BITS + 1)'(8 << RATE_FRAC_BITS);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_TICK        = 4'd0,
        ACT_PLAY        = 4'd1,
        ACT_STOP        = 4'd2,
        ACT_RECORD      = 4'd3,
        ACT_STOP_REC    = 4'd4,
        ACT_TOGGLE_REC  = 4'd5,
        ACT_PANIC       = 4'd6,
        ACT_SEEK        = 4'd7,
        ACT_SET_ARMED   = 4'd8,
        ACT_SET_OVERDUB = 4'd9
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOOP_ENABLE = 2'd0,
        CFG_LOOP_START  = 2'd1,
        CFG_LOOP_END    = 2'd2,
        CFG_SPEED_RATE  = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_ADD,
        S_CHK,
        S_MOD,
        S_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     loop_enable;
        logic [POSITION_BITS-1:0] loop_start;
        logic [POSITION_BITS-1:0] loop_end;
        logic [RATE_BITS-1:0]     speed_rate;
    } t_cfg;

endpackage

### src/transport_playhead_with_loop_top.sv
// ---------------------------------------------------------------------------
// Transport playhead with loop region
// A command other than a playing tick passes through S_EXEC and S_DONE. A playing tick
// passes through S_EXEC, S_MUL, S_ADD, S_CHK and S_DONE, plus S_MOD and S_FIX when the
// loop wraps, waiting on the bit-serial modulo unit. One command is in flight at a time;
// the next is accepted while the previous result waits on the output register.
// Reset is synchronous and active low; it clears flags, playhead and totals and resets config.
// ---------------------------------------------------------------------------
module transport_playhead_with_loop_top import tph_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [ACTION_BITS-1:0]   i_action,
    input  logic [COUNT_BITS-1:0]    i_sample_count,
    input  logic [POSITION_BITS-1:0] i_seek_position,
    input  logic                     i_flag_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_is_playing,
    output logic                     o_is_recording,
    output logic                     o_is_armed,
    output logic                     o_is_overdub,
    output logic [POSITION_BITS-1:0] o_playhead,
    output logic [POSITION_BITS-1:0] o_processed_total,
    output logic                     o_position_changed,
    output logic                     o_state_changed,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [POSITION_BITS-1:0] i_cfg_wdata
);

    t_cfg cfg;

    t_state r_state, n_state;

    logic                     r_playing, n_playing;
    logic                     r_recording, n_recording;
    logic                     r_armed, n_armed;
    logic                     r_overdub, n_overdub;
    logic [POSITION_BITS-1:0] r_playhead, n_playhead;
    logic [POSITION_BITS-1:0] r_processed, n_processed;
    logic                     r_pos_chg, n_pos_chg;
    logic                     r_st_chg, n_st_chg;
    logic                     r_out_valid, n_out_valid;

    t_action                  r_action, n_action;
    logic [COUNT_BITS-1:0]    r_count, n_count;
    logic [POSITION_BITS-1:0] r_seek, n_seek;
    logic                     r_flag, n_flag;
    logic [PROD_BITS-1:0]     r_prod, n_prod;
    logic [POSITION_BITS-1:0] r_np, n_np;

    logic                     r_o_playing, r_o_recording, r_o_armed, r_o_overdub;
    logic [POSITION_BITS-1:0] r_o_playhead, r_o_processed;
    logic                     r_o_pos_chg, r_o_st_chg;
    logic                     load_out;

    logic                     mod_start;
    logic                     mod_done;
    logic [POSITION_BITS-1:0] mod_rem;
    logic [POSITION_BITS-1:0] mod_dividend;
    logic [POSITION_BITS-1:0] mod_divisor;

    logic [POSITION_BITS:0]   ph_sum;
    logic [POSITION_BITS:0]   pc_sum;
    logic [POSITION_BITS-1:0] wrapped;
    logic                     wrap_hit;

    tph_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tph_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign ph_sum = {1'b0, r_playhead}
                  + {{(POSITION_BITS + 1 - DELTA_BITS){1'b0}},
                     r_prod[PROD_BITS-1:RATE_FRAC_BITS]};
    assign pc_sum = {1'b0, r_processed}
                  + {{(POSITION_BITS + 1 - COUNT_BITS){1'b0}}, r_count};
    assign mod_dividend = r_np - cfg.loop_start;
    assign mod_divisor  = cfg.loop_end - cfg.loop_start;
    assign wrapped      = cfg.loop_start + mod_rem;
    assign wrap_hit     = cfg.loop_enable && (cfg.loop_end > cfg.loop_start)
                       && (r_np >= cfg.loop_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_playing   = r_playing;
        n_recording = r_recording;
        n_armed     = r_armed;
        n_overdub   = r_overdub;
        n_playhead  = r_playhead;
        n_processed = r_processed;
        n_pos_chg   = r_pos_chg;
        n_st_chg    = r_st_chg;
        n_out_valid = r_out_valid;
        n_action    = r_action;
        n_count     = r_count;
        n_seek      = r_seek;
        n_flag      = r_flag;
        n_prod      = r_prod;
        n_np        = r_np;
        mod_start   = 1'b0;
        load_out    = 1'b0;
        o_ready     = 1'b0;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_action  = t_action'(i_action);
                    n_count   = i_sample_count;
                    n_seek    = i_seek_position;
                    n_flag    = i_flag_value;
                    n_pos_chg = 1'b0;
                    n_st_chg  = 1'b0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_action)
                    ACT_TICK: begin
                        if (r_playing) begin
                            n_state = S_MUL;
                        end
                    end
                    ACT_PLAY: begin
                        if (!r_playing) begin
                            n_playing   = 1'b1;
                            n_recording = 1'b0;
                            n_st_chg    = 1'b1;
                        end
                    end
                    ACT_STOP: begin
                        if (r_playing) begin
                            n_playing   = 1'b0;
                            n_recording = 1'b0;
                            n_playhead  = '0;
                            n_st_chg    = 1'b1;
                            n_pos_chg   = 1'b1;
                        end
                    end
                    ACT_RECORD: begin
                        n_st_chg = 1'b1;
                        if (!r_armed) begin
                            n_armed = 1'b1;
                        end else begin
                            n_playing   = 1'b1;
                            n_recording = 1'b1;
                            n_armed     = 1'b0;
                        end
                    end
                    ACT_STOP_REC: begin
                        if (r_recording) begin
                            n_recording = 1'b0;
                            n_st_chg    = 1'b1;
                        end
                    end
                    ACT_TOGGLE_REC: begin
                        if (r_recording) begin
                            n_recording = 1'b0;
                            n_st_chg    = 1'b1;
                        end else if (r_playing) begin
                            n_st_chg = 1'b1;
                            if (!r_armed) begin
                                n_armed = 1'b1;
                            end else begin
                                n_recording = 1'b1;
                                n_armed     = 1'b0;
                            end
                        end else if (!r_armed) begin
                            n_armed  = 1'b1;
                            n_st_chg = 1'b1;
                        end
                    end
                    ACT_PANIC: begin
                        n_playing   = 1'b0;
                        n_recording = 1'b0;
                        n_armed     = 1'b0;
                        n_overdub   = 1'b0;
                        n_playhead  = '0;
                        n_st_chg    = 1'b1;
                        n_pos_chg   = 1'b1;
                    end
                    ACT_SEEK: begin
                        n_pos_chg  = (r_seek != r_playhead);
                        n_playhead = r_seek;
                    end
                    ACT_SET_ARMED: begin
                        if (r_armed != r_flag) begin
                            n_armed  = r_flag;
                            n_st_chg = 1'b1;
                        end
                    end
                    ACT_SET_OVERDUB: begin
                        if (r_overdub != r_flag) begin
                            n_overdub = r_flag;
                            n_st_chg  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                n_prod  = PROD_BITS'(r_count) * PROD_BITS'(cfg.speed_rate);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_np        = ph_sum[POSITION_BITS] ? POS_MAX : ph_sum[POSITION_BITS-1:0];
                n_processed = pc_sum[POSITION_BITS] ? POS_MAX : pc_sum[POSITION_BITS-1:0];
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (wrap_hit) begin
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end else begin
                    n_pos_chg  = (r_np != r_playhead);
                    n_playhead = r_np;
                    n_state    = S_DONE;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_pos_chg  = (wrapped != r_playhead);
                n_playhead = wrapped;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_recording <= 1'b0;
            r_armed     <= 1'b0;
            r_overdub   <= 1'b0;
            r_playhead  <= '0;
            r_processed <= '0;
            r_pos_chg   <= 1'b0;
            r_st_chg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_playing   <= n_playing;
            r_recording <= n_recording;
            r_armed     <= n_armed;
            r_overdub   <= n_overdub;
            r_playhead  <= n_playhead;
            r_processed <= n_processed;
            r_pos_chg   <= n_pos_chg;
            r_st_chg    <= n_st_chg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_count  <= n_count;
        r_seek   <= n_seek;
        r_flag   <= n_flag;
        r_prod   <= n_prod;
        r_np     <= n_np;
        if (load_out) begin
            r_o_playing   <= r_playing;
            r_o_recording <= r_recording;
            r_o_armed     <= r_armed;
            r_o_overdub   <= r_overdub;
            r_o_playhead  <= r_playhead;
            r_o_processed <= r_processed;
            r_o_pos_chg   <= r_pos_chg;
            r_o_st_chg    <= r_st_chg;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_is_playing       = r_o_playing;
    assign o_is_recording     = r_o_recording;
    assign o_is_armed         = r_o_armed;
    assign o_is_overdub       = r_o_overdub;
    assign o_playhead         = r_o_playhead;
    assign o_processed_total  = r_o_processed;
    assign o_position_changed = r_o_pos_chg;
    assign o_state_changed    = r_o_st_chg;

endmodule

### src/tph_mod_unit.sv
// ---------------------------------------------------------------------------
// Transport playhead modulo unit
// Restoring remainder unit that retires one dividend bit per cycle.
// ---------------------------------------------------------------------------
module tph_mod_unit import tph_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [POSITION_BITS-1:0] i_dividend,
    input  logic [POSITION_BITS-1:0] i_divisor,
    output logic                     o_done,
    output logic [POSITION_BITS-1:0] o_rem
);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_BITS-1:0]      r_cnt;
    logic [POSITION_BITS-1:0] r_dvd;
    logic [POSITION_BITS-1:0] r_div;
    logic [POSITION_BITS-1:0] r_rem;
    logic [POSITION_BITS-1:0] n_rem;
    logic [POSITION_BITS:0]   shifted;
    logic [POSITION_BITS:0]   diff;

    always_comb begin
        shifted = {r_rem, r_dvd[POSITION_BITS-1]};
        diff    = shifted - {1'b0, r_div};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = diff[POSITION_BITS-1:0];
        end else begin
            n_rem = shifted[POSITION_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MOD_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[POSITION_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/tph_cfg_regs.sv
// ---------------------------------------------------------------------------
// Transport playhead configuration registers
// Loop region, loop enable and playback rate, with rate range filtering.
// ---------------------------------------------------------------------------
module tph_cfg_regs import tph_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [POSITION_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg                 r_cfg;
    logic [RATE_BITS-1:0] wr_rate;

    assign wr_rate = i_cfg_wdata[RATE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_enable <= 1'b0;
            r_cfg.loop_start  <= '0;
            r_cfg.loop_end    <= '0;
            r_cfg.speed_rate  <= RATE_ONE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_LOOP_ENABLE: r_cfg.loop_enable <= i_cfg_wdata[0];
                CFG_LOOP_START:  r_cfg.loop_start  <= i_cfg_wdata;
                CFG_LOOP_END:    r_cfg.loop_end    <= i_cfg_wdata;
                CFG_SPEED_RATE: begin
                    if ((wr_rate != '0) && ({1'b0, wr_rate} <= RATE_MAX)) begin
                        r_cfg.speed_rate <= wr_rate;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/tph_checker.sv
// ---------------------------------------------------------------------------
// Transport playhead checker
// Port-level properties of the transport playhead, bound to the top level.
// ---------------------------------------------------------------------------
`include "transport_playhead_with_loop_top_defines.svh"

module tph_checker import tph_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic                     o_is_playing,
    input logic                     o_is_recording,
    input logic                     o_is_armed,
    input logic                     o_is_overdub,
    input logic [POSITION_BITS-1:0] o_playhead,
    input logic [POSITION_BITS-1:0] o_processed_total,
    input logic                     o_position_changed,
    input logic                     o_state_changed
);

    `TPH_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
        "second command accepted while one is in flight")
    `TPH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_is_playing) && $stable(o_is_recording)
            && $stable(o_is_armed) && $stable(o_is_overdub)
            && $stable(o_playhead) && $stable(o_processed_total)
            && $stable(o_position_changed) && $stable(o_state_changed),
        "stalled result word changed or dropped")
    `TPH_ASSERT_SAME(a_rec_needs_play, i_clk, i_rst_n, o_valid,
        !o_is_recording || o_is_playing, "recording reported while stopped")

endmodule

bind transport_playhead_with_loop_top tph_checker u_tph_checker (.*);
